>>> rtl/core/fqi_pkg.sv
// ----------------------------------------------------------------------------
// fqi_pkg
// shared types and constants for the queue with positional insert
// ----------------------------------------------------------------------------
package fqi_pkg;

  localparam int CAPACITY = 16;
  localparam int WORD_W   = 32;
  localparam int POS_W    = 5;
  localparam int OCC_W    = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_INSERT = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BADIX = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_SHIFT,
    ACT_PLACE
  } act_t;

  typedef struct packed {
    act_t             act;
    logic [IDX_W-1:0] idx;
  } cell_cmd_t;

endpackage

>>> rtl/core/fqi_cell.sv
// ----------------------------------------------------------------------------
// fqi_cell
// one queue slot: holds, takes its back neighbor on remove, or takes its
// front neighbor / the new word on push or insert
// ----------------------------------------------------------------------------
module fqi_cell
  import fqi_pkg::*;
(
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  input  logic        [IDX_W-1:0]  cell_idx,
  input  logic signed [WORD_W-1:0] ins_value,
  input  logic signed [WORD_W-1:0] prev_q,
  input  logic signed [WORD_W-1:0] next_q,
  output logic signed [WORD_W-1:0] q
);

  logic signed [WORD_W-1:0] q_r;
  logic signed [WORD_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    unique case (cmd.act)
      ACT_SHIFT: q_nxt = next_q;
      ACT_PLACE: begin
        if (cell_idx == cmd.idx) begin
          q_nxt = ins_value;
        end else if (cell_idx > cmd.idx) begin
          q_nxt = prev_q;
        end
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

>>> rtl/core/fqi_ctrl.sv
// ----------------------------------------------------------------------------
// fqi_ctrl
// fill count, request decode into a cell command, and the result register
// ----------------------------------------------------------------------------
module fqi_ctrl
  import fqi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     xfer,
  input  logic        [1:0]        op,
  input  logic        [POS_W-1:0]  position,
  input  logic signed [WORD_W-1:0] head,
  output cell_cmd_t                cmd,
  output logic                     res_valid,
  output logic signed [WORD_W-1:0] res_data,
  output logic        [1:0]        res_status,
  output logic        [OCC_W-1:0]  res_occupancy
);

  logic        [CNT_W-1:0]  count_r, count_nxt;
  logic                     valid_r, valid_nxt;
  logic signed [WORD_W-1:0] data_r, data_nxt;
  status_t                  status_r, status_nxt;
  logic                     full, empty, bad_pos;

  assign full    = (count_r == CNT_W'(CAPACITY));
  assign empty   = (count_r == '0);
  assign bad_pos = (CMP_W'(position) > CMP_W'(count_r));

  always_comb begin
    cmd        = '{act: ACT_HOLD, idx: '0};
    count_nxt  = count_r;
    data_nxt   = '0;
    status_nxt = ST_OK;
    if (xfer) begin
      unique case (op_t'(op))
        OP_PUSH: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            cmd       = '{act: ACT_PLACE, idx: count_r[IDX_W-1:0]};
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_REMOVE: begin
          if (empty) begin
            data_nxt   = '1;
            status_nxt = ST_EMPTY;
          end else begin
            cmd       = '{act: ACT_SHIFT, idx: '0};
            data_nxt  = head;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        OP_INSERT: begin
          if (bad_pos) begin
            status_nxt = ST_BADIX;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            cmd       = '{act: ACT_PLACE, idx: position[IDX_W-1:0]};
            count_nxt = count_r + CNT_W'(1);
          end
        end
        default: status_nxt = ST_OK;
      endcase
    end
  end

  assign valid_nxt = xfer;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r   <= data_nxt;
    status_r <= status_nxt;
  end

  assign res_valid     = valid_r;
  assign res_data      = data_r;
  assign res_status    = status_r;
  assign res_occupancy = OCC_W'(count_r);

endmodule

>>> rtl/core/fifo_queue_with_indexed_insert.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_indexed_insert
// bounded queue of signed words with push, remove front and positional insert
//
//   channel  ports                                   transfer
//   in       start, busy, in_op/position/value       start && !busy
//   out      out_valid, out_data/status/occupancy    out_valid, one cycle
//
// one request per cycle; busy stays low
// the result is registered and appears in the cycle after the transfer
// every cell shifts, places or holds in the same cycle, so the request completes at once
// reset clears the fill count; slot contents are not cleared
// the receiver cannot stall, each result is shown for exactly one cycle
// ----------------------------------------------------------------------------
module fifo_queue_with_indexed_insert
  import fqi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic        [1:0]        in_op,
  input  logic        [POS_W-1:0]  in_position,
  input  logic signed [WORD_W-1:0] in_value,
  output logic                     out_valid,
  output logic signed [WORD_W-1:0] out_data,
  output logic        [1:0]        out_status,
  output logic        [OCC_W-1:0]  out_occupancy
);

  cell_cmd_t                cmd;
  logic                     xfer;
  logic signed [WORD_W-1:0] cell_q [CAPACITY];

  assign busy = 1'b0;
  assign xfer = start && !busy;

  fqi_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .xfer          (xfer),
    .op            (in_op),
    .position      (in_position),
    .head          (cell_q[0]),
    .cmd           (cmd),
    .res_valid     (out_valid),
    .res_data      (out_data),
    .res_status    (out_status),
    .res_occupancy (out_occupancy)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [WORD_W-1:0] prev_q;
    logic signed [WORD_W-1:0] next_q;

    if (i == 0) begin : g_front
      assign prev_q = in_value;
    end else begin : g_mid_front
      assign prev_q = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_back
      assign next_q = cell_q[i];
    end else begin : g_mid_back
      assign next_q = cell_q[i+1];
    end

    fqi_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .cell_idx  (IDX_W'(i)),
      .ins_value (in_value),
      .prev_q    (prev_q),
      .next_q    (next_q),
      .q         (cell_q[i])
    );
  end

endmodule

>>> rtl/core/fqi_checker.sv
// ----------------------------------------------------------------------------
// fqi_checker
// port-level checks on request/result timing and status consistency
// ----------------------------------------------------------------------------
module fqi_checker
  import fqi_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic        [1:0]        in_op,
  input logic                     out_valid,
  input logic signed [WORD_W-1:0] out_data,
  input logic        [1:0]        out_status,
  input logic        [OCC_W-1:0]  out_occupancy
);

  // every transfer gives one result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("missing result after transfer");

  // no result without a transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without transfer");

  // empty remove reports minus one and a zero count
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_occupancy == '0 && out_data == '1))
    else $error("empty status inconsistent");

  // full status only when the store is at capacity
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_occupancy == OCC_W'(CAPACITY)))
    else $error("full status below capacity");

  // a push that is not refused as full leaves at least one word
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == OP_PUSH) |=> (out_status == ST_FULL || out_occupancy != '0))
    else $error("push left store empty");

endmodule

bind fifo_queue_with_indexed_insert fqi_checker u_fqi_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_op         (in_op),
  .out_valid     (out_valid),
  .out_data      (out_data),
  .out_status    (out_status),
  .out_occupancy (out_occupancy)
);

>>> tb/sv/fqi_checker.sv
// ----------------------------------------------------------------------------
// fqi_scoreboard
// watches the request and result channels of the queue with positional
// insert, keeps its own copy of the stored words and fill count, predicts
// the result of every request transfer and compares each result transfer
// field by field with the oldest prediction
// ----------------------------------------------------------------------------
module fqi_scoreboard
  import fqi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic        [1:0]        in_op,
  input  logic        [POS_W-1:0]  in_position,
  input  logic signed [WORD_W-1:0] in_value,
  input  logic                     out_valid,
  input  logic signed [WORD_W-1:0] out_data,
  input  logic        [1:0]        out_status,
  input  logic        [OCC_W-1:0]  out_occupancy,
  output int                       pending_results,
  output int                       fail_total
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    status_t                  status;
    logic        [OCC_W-1:0]  occupancy;
  } queue_result_t;

  logic signed [WORD_W-1:0] slot_words [CAPACITY];
  int                       word_count = 0;
  queue_result_t            predicted_results [$];
  int                       backlog = 0;
  int                       error_count = 0;

  assign pending_results = backlog;
  assign fail_total      = error_count;

  task automatic serve_request(input logic [1:0] op, input logic [POS_W-1:0] pos,
                               input logic signed [WORD_W-1:0] word);
    queue_result_t res;
    int            k;
    res.data   = '0;
    res.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (word_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          slot_words[word_count] = word;
          word_count++;
        end
      end
      OP_REMOVE: begin
        if (word_count == 0) begin
          res.data   = -1;
          res.status = ST_EMPTY;
        end else begin
          res.data = slot_words[0];
          for (k = 1; k < word_count; k++) slot_words[k-1] = slot_words[k];
          word_count--;
        end
      end
      OP_INSERT: begin
        if (int'(pos) > word_count) begin
          res.status = ST_BADIX;
        end else if (word_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (k = word_count; k > int'(pos); k--) slot_words[k] = slot_words[k-1];
          slot_words[pos] = word;
          word_count++;
        end
      end
      default: ;
    endcase
    res.occupancy = OCC_W'(word_count);
    predicted_results.push_back(res);
  endtask

  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      word_count = 0;
      predicted_results.delete();
    end else begin
      if (start && !busy) serve_request(in_op, in_position, in_value);
      if (out_valid) begin
        if (predicted_results.size() == 0) begin
          if (error_count < 10)
            $display("%0t: result transfer with no request waiting: %s %0d %0d %0d",
                     $realtime, "data/status/occupancy",
                     out_data, out_status, out_occupancy);
          error_count++;
        end else begin
          want = predicted_results.pop_front();
          if (out_data !== want.data || out_status !== want.status ||
              out_occupancy !== want.occupancy) begin
            if (error_count < 10)
              $display("%0t: mismatch: data exp %0d got %0d, status exp %0d got %0d,%s",
                       $realtime, want.data, out_data, want.status, out_status,
                       $sformatf(" occupancy exp %0d got %0d",
                                 want.occupancy, out_occupancy));
            error_count++;
          end
        end
      end
    end
    backlog <= predicted_results.size();
  end

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives the queue with positional insert: a directed pass over empty, full,
// bad-position and unused-op cases, then random requests whose mix moves the
// queue between nearly empty and full, with random gaps in the request flow;
// the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fqi_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         RANDOM_ITEMS   = 400;
  localparam int         QUIET_TAIL     = 80;
  localparam int         WATCHDOG_LIMIT = 2000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic        [1:0]        in_op = OP_PUSH;
  logic        [POS_W-1:0]  in_position = '0;
  logic signed [WORD_W-1:0] in_value = '0;
  logic                     out_valid;
  logic signed [WORD_W-1:0] out_data;
  logic        [1:0]        out_status;
  logic        [OCC_W-1:0]  out_occupancy;
  int                       pending_results;
  int                       fail_total;
  int                       quiet_cycles = 0;
  int                       level = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fifo_queue_with_indexed_insert i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_position   (in_position),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  fqi_scoreboard i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_data        (out_data),
    .out_status      (out_status),
    .out_occupancy   (out_occupancy),
    .pending_results (pending_results),
    .fail_total      (fail_total)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one request transfer; level tracks the fill count for position choice
  task automatic issue(input logic [1:0] op, input logic [POS_W-1:0] pos,
                       input logic [WORD_W-1:0] word);
    start       <= 1'b1;
    in_op       <= op;
    in_position <= pos;
    in_value    <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (op)
      OP_PUSH:   if (level < CAPACITY) level++;
      OP_REMOVE: if (level > 0) level--;
      OP_INSERT: if (int'(pos) <= level && level < CAPACITY) level++;
      default: ;
    endcase
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int                      grow_pct;
    int                      r;
    logic [1:0]              op;
    logic [POS_W-1:0]        pos;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue, bad positions, extremes, insert at count, unused op
    issue(OP_REMOVE, '0, 32'h1234_5678);
    issue(OP_INSERT, 5'd1, 32'h0BAD_0001);
    issue(OP_INSERT, 5'd31, 32'h0BAD_0002);
    issue(OP_INSERT, 5'd0, 32'h8000_0000);
    issue(OP_PUSH, 5'd31, 32'h7FFF_FFFF);
    issue(OP_INSERT, 5'd2, 32'hFFFF_FFFF);
    issue(OP_INSERT, 5'd1, 32'h5555_5555);
    issue(OP_UNUSED, 5'd31, 32'hFFFF_FFFF);
    for (int k = 0; k < 12; k++) issue(OP_PUSH, 5'(k), $urandom);
    // full queue
    issue(OP_PUSH, '0, 32'hAAAA_AAAA);
    issue(OP_INSERT, 5'd5, 32'h0000_0001);
    issue(OP_INSERT, 5'd17, 32'h0000_0002);
    issue(OP_INSERT, 5'd16, 32'h0000_0003);
    issue(OP_REMOVE, 5'd31, 32'hFFFF_FFFF);

    grow_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0:       grow_pct = 85;
          1:       grow_pct = 15;
          default: grow_pct = 50;
        endcase
      end
      if (n == RANDOM_ITEMS / 2) drain_results();
      r = $urandom_range(0, 99);
      if (r < 2) begin
        op = OP_UNUSED;
      end else if (r < grow_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH : OP_INSERT;
      end else begin
        op = OP_REMOVE;
      end
      case ($urandom_range(0, 9))
        0:       pos = POS_W'($urandom_range(0, 31));
        1:       pos = POS_W'(level);
        default: pos = POS_W'($urandom_range(0, level));
      endcase
      issue(op, pos, pick_word());
      if (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 5) == 0)
        hold_off($urandom_range(1, 19));
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (fail_total == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
